// ===== design/mpgt_pkg.sv =====
// Shared types and constants for the pinch gesture tracker.
// No dependencies.
package mpgt_pkg;
	localparam logic [1:0] OP_DOWN = 2'd0;
	localparam logic [1:0] OP_UP = 2'd1;
	localparam logic [1:0] OP_MOVE = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;
	localparam logic [1:0] KIND_GESTURE = 2'd3;
	localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic lookup;     // apply table update, latch decision
		logic pair_init;  // start pair walk and centroid division
		logic pair_next;  // advance pair pointer
		logic sqrt_start; // start root of current pair
		logic sqrt_step;  // one root iteration
		logic sum_acc;    // accumulate finished root
		logic div_step;   // one centroid divide iteration
		logic finish;     // commit gesture
	} mpgt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic emit_pass;  // pass the event on
		logic do_gesture; // all fingers marked
		logic pair_ok;    // current pair is two valid slots
		logic pair_done;  // pair walk finished
		logic sqrt_done;
		logic div_done;
	} mpgt_sts_t;
endpackage

// ===== design/mpgt_ctrl.sv =====
// Controller state machine of the pinch gesture tracker.
// Depends on mpgt_pkg.
module mpgt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic strobe,
	output logic sel_gesture,
	output mpgt_pkg::mpgt_cmd_t cmd,
	input mpgt_pkg::mpgt_sts_t sts
);
	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_DECIDE, S_PAIR, S_ROOT, S_DIV, S_FIN
	} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && start;
		cmd.lookup = (state_q == S_LOOK);
		case (state_q)
			S_DECIDE: cmd.pair_init = sts.do_gesture;
			S_PAIR: begin
				if (!sts.pair_done) begin
					if (sts.pair_ok) cmd.sqrt_start = 1'b1;
					else cmd.pair_next = 1'b1;
				end
			end
			S_ROOT: begin
				if (sts.sqrt_done) begin
					cmd.sum_acc = 1'b1;
					cmd.pair_next = 1'b1;
				end else cmd.sqrt_step = 1'b1;
			end
			S_DIV: cmd.div_step = !sts.div_done;
			S_FIN: cmd.finish = 1'b1;
			default: ;
		endcase
		// divider runs alongside the pair walk
		if (state_q == S_PAIR || state_q == S_ROOT) cmd.div_step = !sts.div_done;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strobe <= 1'b0;
			sel_gesture <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_LOOK;
				S_LOOK: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.do_gesture) state_q <= S_PAIR;
					else begin
						strobe <= sts.emit_pass;
						sel_gesture <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_PAIR: begin
					if (sts.pair_done) state_q <= S_DIV;
					else if (sts.pair_ok) state_q <= S_ROOT;
				end
				S_ROOT: if (sts.sqrt_done) state_q <= S_PAIR;
				S_DIV: if (sts.div_done) state_q <= S_FIN;
				S_FIN: begin
					strobe <= 1'b1;
					sel_gesture <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy || $past(state_q) == S_FIN || $past(state_q) == S_DECIDE)
		else $error("strobe outside completion");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load) else $error("load while busy");
	a_root_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sqrt_start && cmd.sqrt_step)) else $error("root start and step");
endmodule

// ===== design/mpgt_dp.sv =====
// Datapath of the pinch gesture tracker: finger table, root and divide units.
// Depends on mpgt_pkg.
module mpgt_dp #(
	parameter int MaxTouches = 8
) (
	input logic clk,
	input logic arst_n,
	input mpgt_pkg::mpgt_cmd_t cmd,
	output mpgt_pkg::mpgt_sts_t sts,
	input logic sel_gesture,
	input logic [1:0] op,
	input logic [15:0] finger_id,
	input logic [15:0] device_id,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic signed [16:0] move_x,
	input logic signed [16:0] move_y,
	input logic [15:0] pressure,
	output logic [1:0] kind,
	output logic [15:0] index_or_count,
	output logic [15:0] device_out,
	output logic [15:0] pressure_out,
	output logic [15:0] loc_x,
	output logic [15:0] loc_y,
	output logic signed [16:0] delta_a,
	output logic signed [22:0] delta_b
);
	localparam int IW = (MaxTouches > 1) ? $clog2(MaxTouches) : 1;
	localparam int CW = $clog2(MaxTouches + 1);
	localparam int SW = 16 + CW;
	localparam logic [21:0] DIST_MAX_L = mpgt_pkg::DIST_MAX;

	logic [1:0] op_q;
	logic [15:0] fid_q, dev_q, px_q, py_q, pr_q;
	logic signed [16:0] mx_q, my_q;

	logic [MaxTouches-1:0] valid_q, marked_q;
	logic [15:0] fing_q [MaxTouches];
	logic [15:0] sx_q [MaxTouches];
	logic [15:0] sy_q [MaxTouches];
	logic [21:0] last_q;

	// lookup
	logic found, has_free;
	logic [IW-1:0] found_idx, free_idx;
	logic [CW-1:0] count;
	always_comb begin
		found = 1'b0; has_free = 1'b0; found_idx = '0; free_idx = '0; count = '0;
		for (int i = 0; i < MaxTouches; i++) begin
			if (valid_q[i]) begin
				count = count + CW'(1);
				if (!found && fing_q[i] == fid_q) begin
					found = 1'b1; found_idx = IW'(i);
				end
			end else if (!has_free) begin
				has_free = 1'b1; free_idx = IW'(i);
			end
		end
	end

	logic pass_q, gest_q;
	logic [CW-1:0] n_q;
	logic [MaxTouches-1:0] marked_nx;
	always_comb begin
		marked_nx = marked_q;
		marked_nx[found_idx] = 1'b1;
	end

	// pair walk
	logic [IW-1:0] pi_q, pj_q;
	logic pdone_q;
	logic [21:0] sum_q;
	// root unit: operand up to 33 bits, 17 iterations of 2 bits
	logic [33:0] rv_q, rr_q;
	logic [4:0] rcnt_q;
	logic signed [16:0] dx, dy;
	logic [33:0] sq;
	assign dx = $signed({1'b0, sx_q[pi_q]}) - $signed({1'b0, sx_q[pj_q]});
	assign dy = $signed({1'b0, sy_q[pi_q]}) - $signed({1'b0, sy_q[pj_q]});
	assign sq = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
	logic [33:0] rbit, rtry;
	assign rbit = 34'd1 << {rcnt_q, 1'b0};
	assign rtry = rr_q + rbit;

	// divide unit: restoring, both axes together
	logic [SW-1:0] nx_q, ny_q;
	logic [CW-1:0] rx_q, ry_q;
	logic [5:0] dcnt_q;
	logic [CW:0] tx, ty;
	assign tx = {rx_q, nx_q[SW-1]};
	assign ty = {ry_q, ny_q[SW-1]};

	logic [SW-1:0] accx, accy;
	always_comb begin
		accx = '0; accy = '0;
		for (int i = 0; i < MaxTouches; i++)
			if (valid_q[i]) begin
				accx = accx + SW'(sx_q[i]);
				accy = accy + SW'(sy_q[i]);
			end
	end

	logic [22:0] sum_nx;
	assign sum_nx = 23'(sum_q) + 23'(rr_q[16:0]);

	assign sts.emit_pass = pass_q;
	assign sts.do_gesture = gest_q;
	assign sts.pair_ok = valid_q[pi_q] && valid_q[pj_q] && (pj_q > pi_q);
	assign sts.pair_done = pdone_q;
	assign sts.sqrt_done = (rcnt_q == 5'd31);
	assign sts.div_done = (dcnt_q == 6'(SW));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; fid_q <= finger_id; dev_q <= device_id;
			px_q <= pos_x; py_q <= pos_y; mx_q <= move_x; my_q <= move_y;
			pr_q <= pressure;
		end
		if (cmd.lookup) begin
			n_q <= count;
			if (op_q == mpgt_pkg::OP_DOWN || op_q == mpgt_pkg::OP_MOVE) begin
				if (!found && has_free) begin
					fing_q[free_idx] <= fid_q;
					sx_q[free_idx] <= px_q; sy_q[free_idx] <= py_q;
				end else if (found && count > CW'(1)) begin
					sx_q[found_idx] <= px_q; sy_q[found_idx] <= py_q;
				end
			end
		end
		if (cmd.pair_init) begin
			pi_q <= '0; pj_q <= '0; pdone_q <= 1'b0; sum_q <= '0;
			nx_q <= accx + SW'(n_q >> 1); ny_q <= accy + SW'(n_q >> 1);
			rx_q <= '0; ry_q <= '0; dcnt_q <= '0;
		end
		if (cmd.pair_next) begin
			if (pj_q == IW'(MaxTouches - 1)) begin
				if (pi_q == IW'(MaxTouches - 1)) pdone_q <= 1'b1;
				else pi_q <= pi_q + IW'(1);
				pj_q <= '0;
			end else pj_q <= pj_q + IW'(1);
		end
		if (cmd.sqrt_start) begin
			rv_q <= sq; rr_q <= '0; rcnt_q <= 5'd16;
		end
		if (cmd.sqrt_step) begin
			if (rv_q >= rtry) begin
				rv_q <= rv_q - rtry; rr_q <= (rr_q >> 1) + rbit;
			end else rr_q <= rr_q >> 1;
			rcnt_q <= rcnt_q - 5'd1;
		end
		if (cmd.sum_acc) sum_q <= (sum_nx > 23'(DIST_MAX_L)) ? DIST_MAX_L : sum_nx[21:0];
		if (cmd.div_step) begin
			if (tx >= {1'b0, n_q}) begin
				rx_q <= CW'(tx - {1'b0, n_q}); nx_q <= {nx_q[SW-2:0], 1'b1};
			end else begin
				rx_q <= tx[CW-1:0]; nx_q <= {nx_q[SW-2:0], 1'b0};
			end
			if (ty >= {1'b0, n_q}) begin
				ry_q <= CW'(ty - {1'b0, n_q}); ny_q <= {ny_q[SW-2:0], 1'b1};
			end else begin
				ry_q <= ty[CW-1:0]; ny_q <= {ny_q[SW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; marked_q <= '0; last_q <= '0;
			pass_q <= 1'b0; gest_q <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				pass_q <= 1'b0; gest_q <= 1'b0;
				if (op_q == mpgt_pkg::OP_UP) begin
					if (found) valid_q[found_idx] <= 1'b0;
					marked_q <= '0; last_q <= '0; pass_q <= 1'b1;
				end else if (op_q == mpgt_pkg::OP_DOWN || op_q == mpgt_pkg::OP_MOVE) begin
					if (!found) begin
						if (has_free) begin
							valid_q[free_idx] <= 1'b1;
							marked_q <= '0; last_q <= '0; pass_q <= 1'b1;
						end
					end else if (count <= CW'(1)) pass_q <= 1'b1;
					else if ((marked_nx & valid_q) == valid_q) gest_q <= 1'b1;
					else marked_q <= marked_nx;
				end
			end
			if (cmd.finish) begin
				last_q <= sum_q; marked_q <= '0;
			end
		end
	end

	logic signed [22:0] pdelta;
	assign pdelta = (last_q == '0) ? '0 : $signed({1'b0, sum_q}) - $signed({1'b0, last_q});

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			kind <= mpgt_pkg::KIND_GESTURE;
			index_or_count <= 16'(n_q);
			loc_x <= nx_q[15:0]; loc_y <= ny_q[15:0];
			delta_a <= '0; delta_b <= pdelta;
		end else if (!sel_gesture || cmd.lookup) begin
			kind <= op_q; index_or_count <= fid_q;
			loc_x <= px_q; loc_y <= py_q;
			delta_a <= mx_q; delta_b <= 23'(my_q);
		end
		device_out <= dev_q; pressure_out <= pr_q;
	end

	a_sum_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_acc |=> sum_q <= DIST_MAX_L) else $error("pinch sum over cap");
	a_gest_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pair_init |-> gest_q) else $error("pair walk without gesture");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_acc |-> rr_q[33:17] == '0) else $error("root too wide");
endmodule

// ===== design/multitouch_pinch_gesture_tracker_top.sv =====
// Top level of the pinch gesture tracker.
// Depends on mpgt_pkg, mpgt_ctrl and mpgt_dp.
//
// channel | handshake        | fields
// event   | start / busy     | op finger_id device_id pos_x pos_y move_x move_y pressure
// result  | strobe (1 cycle) | kind index_or_count device_out pressure_out loc_x loc_y
//         |                  | delta_a delta_b
//
// A passed or dropped event goes from idle through the lookup and decide states
// back to idle. A gesture walks all slot pair positions and takes the root of
// each valid pair, the centroid divider running alongside; it then waits for the
// divider to finish and commits the gesture.
// Reset clears the table valid and mark bits and the stored pinch sum.
// The receiver cannot stall: each result is shown for one cycle with strobe.
module multitouch_pinch_gesture_tracker_top #(
	parameter int MAX_TOUCHES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] op,
	input logic [15:0] finger_id,
	input logic [15:0] device_id,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic signed [16:0] move_x,
	input logic signed [16:0] move_y,
	input logic [15:0] pressure,
	output logic strobe,
	output logic [1:0] kind,
	output logic [15:0] index_or_count,
	output logic [15:0] device_out,
	output logic [15:0] pressure_out,
	output logic [15:0] loc_x,
	output logic [15:0] loc_y,
	output logic signed [16:0] delta_a,
	output logic signed [22:0] delta_b
);
	mpgt_pkg::mpgt_cmd_t cmd;
	mpgt_pkg::mpgt_sts_t sts;
	logic sel_gesture;

	mpgt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
		.sel_gesture(sel_gesture), .cmd(cmd), .sts(sts)
	);

	mpgt_dp #(.MaxTouches(MAX_TOUCHES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sel_gesture(sel_gesture),
		.op(op), .finger_id(finger_id), .device_id(device_id), .pos_x(pos_x),
		.pos_y(pos_y), .move_x(move_x), .move_y(move_y), .pressure(pressure),
		.kind(kind), .index_or_count(index_or_count), .device_out(device_out),
		.pressure_out(pressure_out), .loc_x(loc_x), .loc_y(loc_y),
		.delta_a(delta_a), .delta_b(delta_b)
	);
endmodule

// ===== tb/pinch_checker.sv =====
// Checker for the pinch gesture tracker: watches event and result transfers,
// predicts results from its own copy of the finger table and compares them.
// Depends on mpgt_pkg.
module pinch_checker #(
	parameter int MAX_TOUCHES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] op,
	input logic [15:0] finger_id,
	input logic [15:0] device_id,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic signed [16:0] move_x,
	input logic signed [16:0] move_y,
	input logic [15:0] pressure,
	input logic strobe,
	input logic [1:0] kind,
	input logic [15:0] index_or_count,
	input logic [15:0] device_out,
	input logic [15:0] pressure_out,
	input logic [15:0] loc_x,
	input logic [15:0] loc_y,
	input logic signed [16:0] delta_a,
	input logic signed [22:0] delta_b,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] idx;
		logic [15:0] dev;
		logic [15:0] pr;
		logic [15:0] x;
		logic [15:0] y;
		logic [16:0] da;
		logic [22:0] db;
	} touch_result_t;

	touch_result_t expected_q[$];
	bit slot_used[MAX_TOUCHES];
	bit slot_mark[MAX_TOUCHES];
	logic [15:0] slot_id[MAX_TOUCHES];
	logic [15:0] slot_px[MAX_TOUCHES];
	logic [15:0] slot_py[MAX_TOUCHES];
	logic [21:0] prev_spread;

	assign pending = expected_q.size();

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [21:0] finger_spread();
		longint unsigned s;
		longint dx, dy;
		s = 0;
		for (int i = 0; i < MAX_TOUCHES; i++)
			for (int j = i + 1; j < MAX_TOUCHES; j++)
				if (slot_used[i] && slot_used[j]) begin
					dx = longint'(slot_px[i]) - longint'(slot_px[j]);
					dy = longint'(slot_py[i]) - longint'(slot_py[j]);
					s += int_root(dx * dx + dy * dy);
					if (s > mpgt_pkg::DIST_MAX)
						s = mpgt_pkg::DIST_MAX;
				end
		return s[21:0];
	endfunction

	task automatic track_event();
		int hit, hole, n;
		bit all_done;
		touch_result_t r;
		longint unsigned sx, sy;
		logic [21:0] spread;
		longint d;
		hit = -1;
		hole = -1;
		n = 0;
		all_done = 1;
		if (op != mpgt_pkg::OP_DOWN && op != mpgt_pkg::OP_UP && op != mpgt_pkg::OP_MOVE)
			return;
		for (int i = 0; i < MAX_TOUCHES; i++)
			if (slot_used[i]) begin
				n++;
				if (hit < 0 && slot_id[i] == finger_id)
					hit = i;
			end else if (hole < 0)
				hole = i;
		r = '{op, finger_id, device_id, pressure, pos_x, pos_y, move_x,
			{{6{move_y[16]}}, move_y}};
		if (op == mpgt_pkg::OP_UP) begin
			if (hit >= 0)
				slot_used[hit] = 0;
			slot_mark = '{default: 0};
			prev_spread = '0;
			expected_q.push_back(r);
			return;
		end
		if (hit < 0) begin
			if (hole < 0)
				return;
			slot_used[hole] = 1;
			slot_id[hole] = finger_id;
			slot_px[hole] = pos_x;
			slot_py[hole] = pos_y;
			slot_mark = '{default: 0};
			prev_spread = '0;
			expected_q.push_back(r);
			return;
		end
		if (n <= 1) begin
			expected_q.push_back(r);
			return;
		end
		slot_px[hit] = pos_x;
		slot_py[hit] = pos_y;
		slot_mark[hit] = 1;
		for (int i = 0; i < MAX_TOUCHES; i++)
			if (slot_used[i] && !slot_mark[i])
				all_done = 0;
		if (!all_done)
			return;
		sx = 0;
		sy = 0;
		for (int i = 0; i < MAX_TOUCHES; i++)
			if (slot_used[i]) begin
				sx += slot_px[i];
				sy += slot_py[i];
			end
		spread = finger_spread();
		d = (prev_spread != 0) ? longint'(spread) - longint'(prev_spread) : 0;
		prev_spread = spread;
		slot_mark = '{default: 0};
		r.kind = mpgt_pkg::KIND_GESTURE;
		r.idx = 16'(n);
		r.x = 16'((sx + n / 2) / n);
		r.y = 16'((sy + n / 2) / n);
		r.da = '0;
		r.db = d[22:0];
		expected_q.push_back(r);
	endtask

	task automatic compare_result();
		touch_result_t e;
		if (expected_q.size() == 0) begin
			$error("unexpected result kind %0d", kind);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (kind !== e.kind) begin
			$error("kind: expected %0d got %0d", e.kind, kind); fail_count++;
		end
		if (index_or_count !== e.idx) begin
			$error("index_or_count: expected %0d got %0d", e.idx, index_or_count);
			fail_count++;
		end
		if (device_out !== e.dev) begin
			$error("device_out: expected %0d got %0d", e.dev, device_out); fail_count++;
		end
		if (pressure_out !== e.pr) begin
			$error("pressure_out: expected %0d got %0d", e.pr, pressure_out); fail_count++;
		end
		if (loc_x !== e.x) begin
			$error("loc_x: expected %0d got %0d", e.x, loc_x); fail_count++;
		end
		if (loc_y !== e.y) begin
			$error("loc_y: expected %0d got %0d", e.y, loc_y); fail_count++;
		end
		if (delta_a !== e.da) begin
			$error("delta_a: expected %0d got %0d", $signed(e.da), delta_a); fail_count++;
		end
		if (delta_b !== e.db) begin
			$error("delta_b: expected %0d got %0d", $signed(e.db), delta_b); fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		prev_spread = '0;
		slot_used = '{default: 0};
		slot_mark = '{default: 0};
	end

	// results come before the event of the same edge can have been processed
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1)
				compare_result();
			if (start && !busy)
				track_event();
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Top of the pinch gesture tracker testbench: clock, reset, event stimulus
// and verdict. Depends on mpgt_pkg, the tracker top and pinch_checker.
module testbench;
	localparam int MAX_TOUCHES = 8;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] op = mpgt_pkg::OP_DOWN;
	logic [15:0] finger_id = '0;
	logic [15:0] device_id = '0;
	logic [15:0] pos_x = '0;
	logic [15:0] pos_y = '0;
	logic signed [16:0] move_x = '0;
	logic signed [16:0] move_y = '0;
	logic [15:0] pressure = '0;
	logic strobe;
	logic [1:0] kind;
	logic [15:0] index_or_count, device_out, pressure_out, loc_x, loc_y;
	logic signed [16:0] delta_a;
	logic signed [22:0] delta_b;
	int fail_count, pending;
	int cycles = 0;
	bit calm = 0;
	logic [15:0] live_ids[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	multitouch_pinch_gesture_tracker_top #(.MAX_TOUCHES(MAX_TOUCHES)) u_dut (.*);

	pinch_checker #(.MAX_TOUCHES(MAX_TOUCHES)) u_check (.*);

	function automatic logic signed [16:0] rand_motion();
		return $signed(17'($urandom_range(131070))) - 17'sd65535;
	endfunction

	// hold one event until it is taken; start stays high for the next one
	task automatic send_event(logic [1:0] o, logic [15:0] f, logic [15:0] x,
			logic [15:0] y, logic signed [16:0] mx, logic signed [16:0] my);
		if (!calm && $urandom_range(3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1;
		op <= o;
		finger_id <= f;
		device_id <= 16'($urandom);
		pos_x <= x;
		pos_y <= y;
		move_x <= mx;
		move_y <= my;
		pressure <= 16'($urandom);
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic wait_drained();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// move every live finger once so that a gesture completes
	task automatic sweep_fingers();
		foreach (live_ids[k])
			send_event(mpgt_pkg::OP_MOVE, live_ids[k], 16'($urandom), 16'($urandom),
				rand_motion(), rand_motion());
	endtask

	initial begin
		logic [15:0] f;
		int choice;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, lone finger, full table, unknown up, bad opcode
		send_event(mpgt_pkg::OP_DOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd65535,
			-17'sd65535);
		send_event(mpgt_pkg::OP_MOVE, 16'hFFFF, 16'h0000, 16'h0000, -17'sd65535,
			17'sd65535);
		send_event(mpgt_pkg::OP_DOWN, 16'h0000, 16'h0000, 16'h0000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_MOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd1, -17'sd1);
		send_event(mpgt_pkg::OP_DOWN, 16'h0000, 16'h0000, 16'h0000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_MOVE, 16'hFFFF, 16'h8000, 16'h8000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_MOVE, 16'h0000, 16'h0000, 16'h0000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_RSVD, 16'h0000, 16'h1234, 16'h4321, 17'sd5, 17'sd5);
		for (int i = 2; i < MAX_TOUCHES + 1; i++)
			send_event(mpgt_pkg::OP_DOWN, 16'(i), (i & 1) ? 16'hFFFF : 16'h0000,
				(i & 2) ? 16'hFFFF : 16'h0000, 17'sd0, 17'sd0);
		for (int i = 0; i < MAX_TOUCHES - 2; i++)
			send_event(mpgt_pkg::OP_MOVE, 16'(i + 2), (i & 1) ? 16'hFFFF : 16'h0000,
				(i & 2) ? 16'hFFFF : 16'h0000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_MOVE, 16'hFFFF, 16'hFFFF, 16'h0000, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_MOVE, 16'h0000, 16'h0000, 16'hFFFF, 17'sd0, 17'sd0);
		send_event(mpgt_pkg::OP_UP, 16'h7777, 16'h0, 16'h0, 17'sd0, 17'sd0);
		for (int i = 0; i < MAX_TOUCHES + 1; i++)
			send_event(mpgt_pkg::OP_UP, (i == MAX_TOUCHES) ? 16'hFFFF : 16'(i), 16'h0,
				16'h0, 17'sd0, 17'sd0);
		wait_drained();

		// random: build small finger sets, sweep them for gestures, then break up
		for (int round = 0; round < 14; round++) begin
			if (round == 11)
				calm = 1;
			live_ids.delete();
			repeat ($urandom_range(2, (round % 6 == 0) ? MAX_TOUCHES : 4)) begin
				f = 16'($urandom_range(15));
				if (!(f inside {live_ids}))
					live_ids.push_back(f);
				send_event(mpgt_pkg::OP_DOWN, f, 16'($urandom), 16'($urandom),
					rand_motion(), rand_motion());
			end
			repeat ($urandom_range(1, 3))
				sweep_fingers();
			repeat ($urandom_range(0, 3)) begin
				choice = $urandom_range(5);
				send_event((choice == 5) ? mpgt_pkg::OP_RSVD : 2'($urandom_range(2)),
					16'($urandom_range(choice == 0 ? 65535 : 15)), 16'($urandom),
					16'($urandom), rand_motion(), rand_motion());
			end
			foreach (live_ids[k])
				send_event(mpgt_pkg::OP_UP, live_ids[k], 16'($urandom), 16'($urandom),
					rand_motion(), rand_motion());
			for (int i = 0; i < 16; i++)
				send_event(mpgt_pkg::OP_UP, 16'(i), 16'($urandom), 16'($urandom),
					rand_motion(), rand_motion());
			if (round == 5)
				wait_drained();
		end

		wait_drained();
		repeat (700) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
